// ===== rtl/bfpa_pkg.sv =====
// Shared constants and types for the best-fit page allocator.
package bfpa_pkg;
   localparam int HEAP_PAGES = 1024;
   localparam int MAX_ALLOCS = 1024;
   localparam int PAGE_W = $clog2(HEAP_PAGES);
   localparam int CNT_W = $clog2(HEAP_PAGES + 1);
   localparam int IDX_W = $clog2(MAX_ALLOCS);
   localparam int ENT_W = $clog2(MAX_ALLOCS + 1);
   localparam int PAGE_SHIFT = 12;

   localparam logic [2:0] OUT_OK = 3'd0;
   localparam logic [2:0] OUT_NO_RUN = 3'd1;
   localparam logic [2:0] OUT_TABLE_FULL = 3'd2;
   localparam logic [2:0] OUT_NOT_FOUND = 3'd3;
   localparam logic [2:0] OUT_ZERO_SIZE = 3'd4;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SCAN   = 10'b0000000010,
      ST_MARK   = 10'b0000000100,
      ST_FIND   = 10'b0000001000,
      ST_FWAIT  = 10'b0000010000,
      ST_SHIFT  = 10'b0000100000,
      ST_SWAIT  = 10'b0001000000,
      ST_CLEAR  = 10'b0010000000,
      ST_RESP   = 10'b0100000000,
      ST_APPEND = 10'b1000000000
   } state_type;
endpackage

// ===== rtl/bfpa_bitmap.sv =====
// Used-page bitmap memory with a registered read port and a clearing pass after reset.
module bfpa_bitmap import bfpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [PAGE_W-1:0] rd_page,
   output logic              rd_used,
   input  logic              wr_en,
   input  logic [PAGE_W-1:0] wr_page,
   input  logic              wr_used,
   output logic              busy
);
   logic              mem [HEAP_PAGES];
   logic              rd_used_ff;
   logic [PAGE_W-1:0] clr_ff;
   logic              busy_ff;

   // After reset every page is written free, one page per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == PAGE_W'(HEAP_PAGES - 1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_page] <= wr_used;
      end
      rd_used_ff <= mem[rd_page];
   end

   assign rd_used = rd_used_ff;
   assign busy = busy_ff;
endmodule

// ===== rtl/bfpa_table.sv =====
// Allocation table memory: one write port, one registered read port.
module bfpa_table import bfpa_pkg::*; (
   input  logic              clock,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [PAGE_W-1:0] rd_start,
   output logic [CNT_W-1:0]  rd_count,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [PAGE_W-1:0] wr_start,
   input  logic [CNT_W-1:0]  wr_count
);
   logic [PAGE_W+CNT_W-1:0] mem [MAX_ALLOCS];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= {wr_count, wr_start};
      {rd_count, rd_start} <= mem[rd_idx];
   end
endmodule

// ===== rtl/best_fit_page_allocator_top.sv =====
// Top level of the best-fit page allocator: sequencer, scan unit and ports.
//
// One transaction on the request channel is handled at a time; the block drops
// req_tready from acceptance until the response is taken. An allocate scans the
// bitmap page by page, with a final step past the last page that closes the
// last run, then marks each page of the chosen run. A free walks the table
// through its single registered read port, a wait state and a find state per
// entry, until the address matches, then moves every later entry down, a wait
// state and a shift state per entry, and clears the run one page per cycle.
// The scan, the marking and the clearing share one page counter. Zero-size,
// full-table and oversized requests, and a free with the table empty, present
// their response in the cycle after acceptance.
// heap_base is written on the csr channel while idle. The entry count is cleared
// by reset; the bitmap is cleared by a pass right after reset, one page per
// cycle, and req_tready stays low until that pass is done.
module best_fit_page_allocator_top import bfpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: [0] mode, [32:1] request_bytes, [64:33] free_address, zero pad to 72
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: [31:0] start_address, [34:32] outcome, zero pad to 40
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   state_type state_ff, state_in;
   logic [31:0] base_ff, addr_ff;
   logic [CNT_W-1:0] need_ff, need_in;
   logic [CNT_W-1:0] pg_ff, pg_in;          // shared page/step counter
   logic [CNT_W-1:0] run_len_ff, run_len_in, best_len_ff, best_len_in;
   logic [PAGE_W-1:0] run_st_ff, run_st_in, best_st_ff, best_st_in;
   logic found_ff, found_in;
   logic [ENT_W-1:0] count_ff, count_in;
   logic [ENT_W-1:0] k_ff, k_in;
   logic [PAGE_W-1:0] fstart_ff, fstart_in;
   logic [CNT_W-1:0] fcount_ff, fcount_in;
   logic [31:0] rs_addr_ff, rs_addr_in;
   logic [2:0] rs_out_ff, rs_out_in;

   logic rd_used, bm_we, bm_val, bm_busy;
   logic [PAGE_W-1:0] bm_rd, bm_wr;
   logic [IDX_W-1:0] t_rd_idx, t_wr_idx;
   logic [PAGE_W-1:0] t_rd_start, t_wr_start;
   logic [CNT_W-1:0] t_rd_count, t_wr_count;
   logic t_we;

   logic [32:0] need_full;
   logic used_now;
   logic [CNT_W:0] mark_pg;

   bfpa_bitmap u_bitmap (
      .clock, .reset, .rd_page(bm_rd), .rd_used,
      .wr_en(bm_we), .wr_page(bm_wr), .wr_used(bm_val), .busy(bm_busy)
   );
   bfpa_table u_table (
      .clock, .rd_idx(t_rd_idx), .rd_start(t_rd_start), .rd_count(t_rd_count),
      .wr_en(t_we), .wr_idx(t_wr_idx), .wr_start(t_wr_start), .wr_count(t_wr_count)
   );

   assign req_tready = (state_ff == ST_IDLE) && !bm_busy;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {5'd0, rs_out_ff, rs_addr_ff};

   // Page count of the request, rounded up; 33 bits so the carry is kept.
   assign need_full = ({1'b0, req_tdata[32:1]} + 33'd4095) >> PAGE_SHIFT;
   // The bitmap read is registered, so rd_used belongs to the page in pg_ff.
   assign used_now  = (pg_ff == CNT_W'(HEAP_PAGES)) || rd_used;
   assign mark_pg   = {1'b0, pg_ff} + {{(CNT_W+1-PAGE_W){1'b0}}, fstart_ff};

   always_comb begin
      state_in = state_ff; need_in = need_ff; pg_in = pg_ff;
      run_len_in = run_len_ff; best_len_in = best_len_ff;
      run_st_in = run_st_ff; best_st_in = best_st_ff; found_in = found_ff;
      count_in = count_ff; k_in = k_ff; fstart_in = fstart_ff; fcount_in = fcount_ff;
      rs_addr_in = rs_addr_ff; rs_out_in = rs_out_ff;
      bm_we = 1'b0; bm_wr = mark_pg[PAGE_W-1:0]; bm_val = 1'b0;
      t_rd_idx = k_ff[IDX_W-1:0]; t_we = 1'b0; t_wr_idx = count_ff[IDX_W-1:0];
      t_wr_start = best_st_ff; t_wr_count = need_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               rs_addr_in = '0; rs_out_in = OUT_OK; pg_in = '0; k_in = '0;
               run_len_in = '0; best_len_in = '1; found_in = 1'b0;
               if (!req_tdata[0]) begin
                  if (req_tdata[32:1] == 32'd0) begin
                     rs_out_in = OUT_ZERO_SIZE; state_in = ST_RESP;
                  end else if (count_ff == ENT_W'(MAX_ALLOCS)) begin
                     rs_out_in = OUT_TABLE_FULL; state_in = ST_RESP;
                  end else if (need_full > 33'(HEAP_PAGES)) begin
                     rs_out_in = OUT_NO_RUN; state_in = ST_RESP;
                  end else begin
                     need_in = CNT_W'(need_full); state_in = ST_SCAN;
                  end
               end else if (count_ff == '0) begin
                  rs_out_in = OUT_NOT_FOUND; state_in = ST_RESP;
               end else begin
                  state_in = ST_FWAIT;
               end
            end
         end
         ST_SCAN: begin
            if (used_now) begin
               if (run_len_ff != '0 && run_len_ff >= need_ff && run_len_ff < best_len_ff) begin
                  best_len_in = run_len_ff; best_st_in = run_st_ff; found_in = 1'b1;
               end
               run_len_in = '0;
            end else begin
               if (run_len_ff == '0) run_st_in = pg_ff[PAGE_W-1:0];
               run_len_in = run_len_ff + 1'b1;
            end
            pg_in = pg_ff + 1'b1;
            if (pg_ff == CNT_W'(HEAP_PAGES)) begin
               pg_in = '0;
               if (found_in) begin
                  // The chosen run may have closed in this very cycle.
                  fstart_in = best_st_in;
                  state_in = ST_MARK;
               end else begin
                  rs_out_in = OUT_NO_RUN; state_in = ST_RESP;
               end
            end
         end
         ST_MARK: begin
            bm_we = 1'b1; bm_val = 1'b1;
            pg_in = pg_ff + 1'b1;
            if (pg_in == need_ff) state_in = ST_APPEND;
         end
         ST_APPEND: begin
            t_we = 1'b1;
            count_in = count_ff + 1'b1;
            rs_addr_in = base_ff + {{(32-PAGE_W-PAGE_SHIFT){1'b0}}, best_st_ff,
                                    {PAGE_SHIFT{1'b0}}};
            state_in = ST_RESP;
         end
         ST_FWAIT: state_in = ST_FIND;  // read data of entry k arrives next cycle
         ST_FIND: begin
            if (base_ff + {{(32-PAGE_W-PAGE_SHIFT){1'b0}}, t_rd_start,
                           {PAGE_SHIFT{1'b0}}} == addr_ff) begin
               fstart_in = t_rd_start; fcount_in = t_rd_count;
               k_in = k_ff + 1'b1; state_in = ST_SWAIT;
            end else if (k_ff + 1'b1 == count_ff) begin
               rs_out_in = OUT_NOT_FOUND; state_in = ST_RESP;
            end else begin
               k_in = k_ff + 1'b1; state_in = ST_FWAIT;
            end
         end
         ST_SWAIT: begin
            if (k_ff == count_ff) begin
               count_in = count_ff - 1'b1; pg_in = '0;
               state_in = (fcount_ff == '0) ? ST_RESP : ST_CLEAR;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // Move entry k down to k-1.
            t_we = 1'b1; t_wr_idx = IDX_W'(k_ff - 1'b1);
            t_wr_start = t_rd_start; t_wr_count = t_rd_count;
            k_in = k_ff + 1'b1; state_in = ST_SWAIT;
         end
         ST_CLEAR: begin
            bm_we = (mark_pg < (CNT_W+1)'(HEAP_PAGES)); bm_val = 1'b0;
            pg_in = pg_ff + 1'b1;
            if (pg_in == fcount_ff) state_in = ST_RESP;
         end
         ST_RESP: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // Read ahead so the next cycle sees the used bit of the next page.
      bm_rd = pg_in[PAGE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; base_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in;
         if (csr_valid && csr_ready) base_ff <= csr_data;
      end
      if (req_tvalid && req_tready) addr_ff <= req_tdata[64:33];
      need_ff <= need_in; pg_ff <= pg_in; run_len_ff <= run_len_in;
      best_len_ff <= best_len_in; run_st_ff <= run_st_in; best_st_ff <= best_st_in;
      found_ff <= found_in; k_ff <= k_in; fstart_ff <= fstart_in; fcount_ff <= fcount_in;
      rs_addr_ff <= rs_addr_in; rs_out_ff <= rs_out_in;
   end
endmodule

// ===== tb/best_fit_page_allocator_top_tb.sv =====
// Self-checking testbench for the best-fit page allocator top level.
`timescale 1ns / 100ps

module best_fit_page_allocator_top_tb;
   import bfpa_pkg::*;

   // Request kinds carried in bit 0 of req_tdata.
   localparam bit MODE_ALLOC = 1'b0;
   localparam bit MODE_FREE = 1'b1;
   localparam int unsigned PAGE_BYTES = 4096;
   localparam int unsigned CYCLE_LIMIT = 8000000;
   localparam int unsigned HOLD_OFF_CYCLES = 3000;

   typedef struct packed {
      logic [31:0] start_address;
      logic [2:0]  outcome;
   } alloc_reply_type;

   // Mirror of the heap: page bitmap, live allocation table and base register.
   // Every accepted request is applied here at once, and the reply it must
   // produce is queued until the block's response transaction arrives.
   class page_heap_type;
      bit               page_used[HEAP_PAGES];
      int unsigned      run_start_page[$];
      int unsigned      run_page_count[$];
      logic [31:0]      heap_base;
      alloc_reply_type  pending_replies[$];
      int unsigned      mismatches;
      int unsigned      outcome_seen[5];

      function logic [31:0] page_address(int unsigned page);
         return heap_base + 32'(page * PAGE_BYTES);
      endfunction

      function void note_request(bit mode, logic [31:0] bytes, logic [31:0] addr);
         alloc_reply_type reply;
         longint unsigned need;
         longint unsigned best_len;
         int unsigned best_start, run_start, run_len, k;
         bit found, busy;
         reply = '{start_address: 32'd0, outcome: OUT_OK};
         if (mode == MODE_ALLOC) begin
            best_len = HEAP_PAGES + 1;
            found = 0;
            run_len = 0;
            run_start = 0;
            best_start = 0;
            need = (longint'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            if (bytes == 0) begin
               reply.outcome = OUT_ZERO_SIZE;
            end else if (run_start_page.size() >= MAX_ALLOCS) begin
               reply.outcome = OUT_TABLE_FULL;
            end else begin
               // Best fit: the shortest free run that is long enough, lowest first.
               for (int p = 0; p <= HEAP_PAGES; p++) begin
                  busy = (p == HEAP_PAGES) || page_used[p];
                  if (busy) begin
                     if (run_len != 0 && run_len >= need && run_len < best_len) begin
                        best_len = run_len;
                        best_start = run_start;
                        found = 1;
                     end
                     run_len = 0;
                  end else begin
                     if (run_len == 0) run_start = p;
                     run_len++;
                  end
               end
               if (!found) begin
                  reply.outcome = OUT_NO_RUN;
               end else begin
                  for (int i = 0; i < need; i++) page_used[best_start + i] = 1;
                  run_start_page.push_back(best_start);
                  run_page_count.push_back(int'(need));
                  reply.start_address = page_address(best_start);
               end
            end
         end else begin
            // The first entry whose address matches under the current base is freed.
            for (k = 0; k < run_start_page.size(); k++)
               if (page_address(run_start_page[k]) == addr) break;
            if (k >= run_start_page.size()) begin
               reply.outcome = OUT_NOT_FOUND;
            end else begin
               for (int i = 0; i < run_page_count[k]; i++)
                  page_used[run_start_page[k] + i] = 0;
               run_start_page.delete(k);
               run_page_count.delete(k);
            end
         end
         outcome_seen[reply.outcome]++;
         pending_replies.push_back(reply);
      endfunction

      function void check_response(logic [31:0] start_address, logic [2:0] outcome);
         alloc_reply_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: response with none expected: start_address %h outcome %0d",
                     $time, start_address, outcome);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         if (start_address !== want.start_address) begin
            $display("%0t: start_address expected %h actual %h", $time,
                     want.start_address, start_address);
            mismatches++;
         end
         if (outcome !== want.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   page_heap_type  heap = new();
   bit             steady;          // while set, neither side inserts idle cycles
   bit             hold_off_req;    // asks the response side for one long stall
   int unsigned    cycle_count;
   int unsigned    alloc_sent, free_sent;

   best_fit_page_allocator_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Watchdog: ends the run with a mismatch report once the cycle count passes CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Every response transaction is compared with the oldest expected reply.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         heap.check_response(rsp_tdata[31:0], rsp_tdata[34:32]);
   end

   // Response side: random back-pressure, plus one long hold-off on request so
   // that the block sits on a finished reply while the sender keeps offering.
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 0;
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 24);
         end
      end
   end

   // Offers one request and returns at the edge where it is accepted, with
   // req_tvalid still high, or after a random gap with req_tvalid low.
   task automatic send_request(bit mode, logic [31:0] bytes, logic [31:0] addr);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, addr, bytes, mode};
      do @(posedge clock); while (!req_tready);
      heap.note_request(mode, bytes, addr);
      if (mode == MODE_ALLOC) alloc_sent++;
      else free_sent++;
      if (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (heap.pending_replies.size() != 0) @(posedge clock);
   endtask

   // The base register is only rewritten once the block has gone idle.
   task automatic write_heap_base(logic [31:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      heap.heap_base = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] live_address();
      int unsigned k;
      k = $urandom_range(heap.run_start_page.size() - 1);
      return heap.page_address(heap.run_start_page[k]);
   endfunction

   // Mostly small requests with the odd large or absurd one; frees mostly hit
   // live allocations, with some stray addresses mixed in.
   task automatic random_requests(int unsigned count);
      int unsigned pick;
      logic [31:0] bytes;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (heap.run_start_page.size() != 0 && pick < 40) begin
            send_request(MODE_FREE, $urandom, live_address());
         end else if (pick < 46) begin
            send_request(MODE_FREE, $urandom, $urandom);
         end else begin
            pick = $urandom_range(99);
            if (pick < 4) bytes = 32'd0;
            else if (pick < 10) bytes = $urandom;
            else if (pick < 16) bytes = $urandom_range(HEAP_PAGES * PAGE_BYTES, 65536);
            else bytes = $urandom_range(8 * PAGE_BYTES, 1);
            send_request(MODE_ALLOC, bytes, $urandom);
         end
      end
   endtask

   initial begin
      logic [31:0] addr;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      steady = 0;
      hold_off_req = 0;
      cycle_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero size, page edges, whole heap, oversized, unknown address.
      write_heap_base(32'h0001_0000);
      send_request(MODE_ALLOC, 32'd0, 32'd0);
      send_request(MODE_ALLOC, 32'd1, 32'hFFFF_FFFF);
      send_request(MODE_ALLOC, 32'd4096, 32'd0);
      send_request(MODE_ALLOC, 32'd4097, 32'd0);
      send_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0);
      send_request(MODE_ALLOC, HEAP_PAGES * PAGE_BYTES, 32'd0);
      send_request(MODE_FREE, 32'hFFFF_FFFF, 32'h0001_1000);
      send_request(MODE_FREE, 32'd0, 32'h0001_1000);
      send_request(MODE_FREE, 32'd0, 32'h1234_5678);
      send_request(MODE_FREE, 32'd0, 32'h0001_0000);
      send_request(MODE_FREE, 32'd0, 32'h0001_2000);
      // The heap is empty again, so the whole heap fits once and no more.
      send_request(MODE_ALLOC, HEAP_PAGES * PAGE_BYTES, 32'd0);
      send_request(MODE_ALLOC, 32'd1, 32'd0);
      send_request(MODE_FREE, 32'd0, 32'h0001_0000);
      // A hole between two runs must be chosen over the larger tail.
      send_request(MODE_ALLOC, 3 * PAGE_BYTES, 32'd0);
      send_request(MODE_ALLOC, 2 * PAGE_BYTES, 32'd0);
      send_request(MODE_ALLOC, PAGE_BYTES, 32'd0);
      send_request(MODE_FREE, 32'd0, 32'h0001_3000);
      send_request(MODE_ALLOC, PAGE_BYTES, 32'd0);

      // Top-of-address-space base: page addresses wrap, and live entries are
      // now looked up under the new base.
      write_heap_base(32'hFFFF_F000);
      steady = 1;
      random_requests(50);
      steady = 0;
      hold_off_req = 1;
      random_requests(40);

      // Unaligned random base.
      write_heap_base($urandom);
      random_requests(60);
      write_heap_base(32'd0);
      random_requests(50);
      write_heap_base({20'($urandom_range(32'hFFFFF, 0)), 12'd0});
      random_requests(40);

      // Empty the table, newest entry first.
      while (heap.run_start_page.size() != 0)
         send_request(MODE_FREE, 32'd0,
                      heap.page_address(heap.run_start_page[heap.run_start_page.size() - 1]));
      // With the table empty any free misses, and an allocate lands on page 0.
      send_request(MODE_FREE, 32'd0, 32'h7FFF_F000);
      send_request(MODE_ALLOC, PAGE_BYTES, 32'd0);
      addr = heap.page_address(heap.run_start_page[0]);
      send_request(MODE_FREE, 32'd0, addr);
      send_request(MODE_ALLOC, PAGE_BYTES, 32'd0);

      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d allocate and %0d free requests over five base settings.",
               alloc_sent, free_sent);
      $display("Replies: ok %0d, no run %0d, table full %0d, not found %0d, zero size %0d.",
               heap.outcome_seen[OUT_OK], heap.outcome_seen[OUT_NO_RUN],
               heap.outcome_seen[OUT_TABLE_FULL], heap.outcome_seen[OUT_NOT_FOUND],
               heap.outcome_seen[OUT_ZERO_SIZE]);
      if (heap.mismatches == 0 && heap.pending_replies.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/bfpa_pkg.sv
rtl/bfpa_bitmap.sv
rtl/bfpa_table.sv
rtl/best_fit_page_allocator_top.sv
tb/best_fit_page_allocator_top_tb.sv
